// ===== hw/rtl/pva_pkg.sv =====
// ----------------------------------------------------------------------------
// pva_pkg
// Shared constants and control types for the priority voice allocator.
// ----------------------------------------------------------------------------
package pva_pkg;

   localparam int MAX_VOICES = 32;
   localparam int VIDX_W     = $clog2(MAX_VOICES);
   localparam int CNT_W      = VIDX_W + 1;
   localparam int SOUND_W    = 8;
   localparam int PRIO_W     = 5;
   localparam int OUTC_W     = 3;

   localparam logic [CNT_W-1:0] LIMIT_RESET = CNT_W'(MAX_VOICES);
   localparam logic [CNT_W-1:0] VOICES_CNT  = CNT_W'(MAX_VOICES);

   localparam logic [OUTC_W-1:0] OUTC_REUSED    = 3'd0;
   localparam logic [OUTC_W-1:0] OUTC_OPENED    = 3'd1;
   localparam logic [OUTC_W-1:0] OUTC_STOLE_LT  = 3'd2;
   localparam logic [OUTC_W-1:0] OUTC_STOLE_LE  = 3'd3;
   localparam logic [OUTC_W-1:0] OUTC_REFUSED   = 3'd4;
   localparam logic [OUTC_W-1:0] OUTC_STOP_DONE = 3'd5;

   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_STOP  = 1'b1;

   typedef struct packed {
      logic start;
      logic step;
      logic restart;
      logic track_le;
      logic do_stop;
      logic do_reuse;
      logic do_open;
      logic do_steal_lt;
      logic do_steal_le;
      logic do_refuse;
      logic load_rsp;
   } pva_cmd_type;

   typedef struct packed {
      logic is_stop;
      logic at_end;
      logic reuse_hit;
      logic can_open;
      logic lower_hit;
      logic le_found;
   } pva_status_type;

endpackage

// ===== hw/rtl/pva_datapath.sv =====
// ----------------------------------------------------------------------------
// pva_datapath
// Voice tables, scan index, decision updates and the result register.
// ----------------------------------------------------------------------------
module pva_datapath
   import pva_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CNT_W-1:0]      csr_wr_data,
   input  logic                  in_req_type,
   input  logic [SOUND_W-1:0]    in_sound_type,
   input  logic [PRIO_W-1:0]     in_sound_priority,
   input  logic [VIDX_W-1:0]     in_target_voice,
   input  pva_cmd_type           cmd,
   output pva_status_type        status,
   output logic                  rsp_granted,
   output logic [VIDX_W-1:0]     rsp_voice_number,
   output logic                  rsp_already_loaded,
   output logic [OUTC_W-1:0]     rsp_outcome
);

   logic [CNT_W-1:0]      limit_ff;
   logic [CNT_W-1:0]      open_count_ff;
   logic [MAX_VOICES-1:0] playing_ff;
   logic [SOUND_W-1:0]    sound_ff [MAX_VOICES];
   logic [PRIO_W-1:0]     rank_ff  [MAX_VOICES];

   logic                  req_type_ff;
   logic [SOUND_W-1:0]    snd_ff;
   logic [PRIO_W-1:0]     pri_ff;
   logic [VIDX_W-1:0]     tgt_ff;
   logic [CNT_W-1:0]      n_ff;
   logic [CNT_W-1:0]      idx_ff;
   logic [VIDX_W-1:0]     le_ff;
   logic                  le_found_ff;

   logic                  res_granted_ff;
   logic [VIDX_W-1:0]     res_voice_ff;
   logic                  res_loaded_ff;
   logic [OUTC_W-1:0]     res_outcome_ff;

   logic                  rsp_granted_ff;
   logic [VIDX_W-1:0]     rsp_voice_ff;
   logic                  rsp_loaded_ff;
   logic [OUTC_W-1:0]     rsp_outcome_ff;

   logic [VIDX_W-1:0]     idx;
   logic [VIDX_W-1:0]     n_idx;
   logic [SOUND_W-1:0]    cur_sound;
   logic [PRIO_W-1:0]     cur_rank;
   logic                  tgt_open;

   assign idx       = idx_ff[VIDX_W-1:0];
   assign n_idx     = n_ff[VIDX_W-1:0];
   assign cur_sound = sound_ff[idx];
   assign cur_rank  = rank_ff[idx];
   assign tgt_open  = {1'b0, tgt_ff} < n_ff;

   assign status.is_stop   = (req_type_ff == REQ_STOP);
   assign status.at_end    = (idx_ff >= n_ff);
   assign status.reuse_hit = !playing_ff[idx] && (cur_sound == snd_ff);
   assign status.can_open  = (n_ff < VOICES_CNT) &&
                             ((n_ff == '0) || (n_ff < limit_ff));
   assign status.lower_hit = (cur_rank < pri_ff);
   assign status.le_found  = le_found_ff;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff      <= LIMIT_RESET;
         open_count_ff <= '0;
         playing_ff    <= '0;
      end else begin
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
         if (cmd.do_stop && tgt_open) begin
            playing_ff[tgt_ff] <= 1'b0;
         end
         if (cmd.do_reuse || cmd.do_steal_lt) begin
            playing_ff[idx] <= 1'b1;
         end
         if (cmd.do_open) begin
            playing_ff[n_idx] <= 1'b1;
            open_count_ff     <= n_ff + 1'b1;
         end
         if (cmd.do_steal_le) begin
            playing_ff[le_ff] <= 1'b1;
         end
      end
   end

   // voice tables and scan registers
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         req_type_ff <= in_req_type;
         snd_ff      <= in_sound_type;
         pri_ff      <= in_sound_priority;
         tgt_ff      <= in_target_voice;
         n_ff        <= (open_count_ff > VOICES_CNT) ? VOICES_CNT : open_count_ff;
         idx_ff      <= '0;
         le_found_ff <= 1'b0;
         le_ff       <= '0;
      end else if (cmd.restart) begin
         idx_ff <= '0;
      end else if (cmd.step) begin
         idx_ff <= idx_ff + 1'b1;
         if (cmd.track_le && (cur_rank <= pri_ff)) begin
            le_found_ff <= 1'b1;
            le_ff       <= idx;
         end
      end
      if (cmd.do_reuse) begin
         rank_ff[idx] <= pri_ff;
      end
      if (cmd.do_open) begin
         sound_ff[n_idx] <= snd_ff;
         rank_ff[n_idx]  <= pri_ff;
      end
      if (cmd.do_steal_lt) begin
         sound_ff[idx] <= snd_ff;
      end
      if (cmd.do_steal_le) begin
         sound_ff[le_ff] <= snd_ff;
      end
   end

   // decision result
   always_ff @(posedge clock) begin
      if (cmd.do_stop) begin
         res_granted_ff <= tgt_open;
         res_voice_ff   <= tgt_open ? tgt_ff : '0;
         res_loaded_ff  <= 1'b0;
         res_outcome_ff <= tgt_open ? OUTC_STOP_DONE : OUTC_REFUSED;
      end else if (cmd.do_reuse) begin
         res_granted_ff <= 1'b1;
         res_voice_ff   <= idx;
         res_loaded_ff  <= 1'b1;
         res_outcome_ff <= OUTC_REUSED;
      end else if (cmd.do_open) begin
         res_granted_ff <= 1'b1;
         res_voice_ff   <= n_idx;
         res_loaded_ff  <= 1'b0;
         res_outcome_ff <= OUTC_OPENED;
      end else if (cmd.do_steal_lt) begin
         res_granted_ff <= 1'b1;
         res_voice_ff   <= idx;
         res_loaded_ff  <= 1'b0;
         res_outcome_ff <= OUTC_STOLE_LT;
      end else if (cmd.do_steal_le) begin
         res_granted_ff <= 1'b1;
         res_voice_ff   <= le_ff;
         res_loaded_ff  <= 1'b0;
         res_outcome_ff <= OUTC_STOLE_LE;
      end else if (cmd.do_refuse) begin
         res_granted_ff <= 1'b0;
         res_voice_ff   <= '0;
         res_loaded_ff  <= 1'b0;
         res_outcome_ff <= OUTC_REFUSED;
      end
   end

   // output word register
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_granted_ff <= res_granted_ff;
         rsp_voice_ff   <= res_voice_ff;
         rsp_loaded_ff  <= res_loaded_ff;
         rsp_outcome_ff <= res_outcome_ff;
      end
   end

   assign rsp_granted        = rsp_granted_ff;
   assign rsp_voice_number   = rsp_voice_ff;
   assign rsp_already_loaded = rsp_loaded_ff;
   assign rsp_outcome        = rsp_outcome_ff;

endmodule

// ===== hw/rtl/pva_controller.sv =====
// ----------------------------------------------------------------------------
// pva_controller
// Sequencer for the reuse scan, open check, steal scan and result handoff.
// ----------------------------------------------------------------------------
module pva_controller
   import pva_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   output logic           rsp_tvalid,
   input  logic           rsp_tready,
   input  pva_status_type status,
   output pva_cmd_type    cmd
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_REUSE  = 2'd1;
   localparam logic [1:0] ST_STEAL  = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.start = 1'b1;
               state_in  = ST_REUSE;
            end
         end
         ST_REUSE: begin
            if (status.is_stop) begin
               cmd.do_stop = 1'b1;
               state_in    = ST_FINISH;
            end else if (status.at_end) begin
               if (status.can_open) begin
                  cmd.do_open = 1'b1;
                  state_in    = ST_FINISH;
               end else begin
                  cmd.restart = 1'b1;
                  state_in    = ST_STEAL;
               end
            end else if (status.reuse_hit) begin
               cmd.do_reuse = 1'b1;
               state_in     = ST_FINISH;
            end else begin
               cmd.step = 1'b1;
            end
         end
         ST_STEAL: begin
            if (status.at_end) begin
               if (status.le_found) begin
                  cmd.do_steal_le = 1'b1;
               end else begin
                  cmd.do_refuse = 1'b1;
               end
               state_in = ST_FINISH;
            end else if (status.lower_hit) begin
               cmd.do_steal_lt = 1'b1;
               state_in        = ST_FINISH;
            end else begin
               cmd.step     = 1'b1;
               cmd.track_le = 1'b1;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== hw/rtl/priority_voice_allocator_core.sv =====
// ----------------------------------------------------------------------------
// priority_voice_allocator_core
// Allocates and stops sound voices by sound reuse, opening and priority steal.
// ----------------------------------------------------------------------------
//  channel   dir   tdata                                   tuser
//  req_      in    sound_type, sound_priority, target_vc   req_type
//  rsp_      out   voice_number                            granted, loaded, outcome
//  csr_      in    voice_limit (write only)                -
//
//  a stop word is decided right after accept, without a scan
//  an allocate word is handled one voice a cycle over the reuse scan and then,
//  if no voice can be opened, over the steal scan
//  one word is in work at a time; the result waits in the output register
//  while the next word may be accepted
//  reset clears the open count and playing flags; voice_limit resets to 32
// ----------------------------------------------------------------------------
module priority_voice_allocator_core
   import pva_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [23:0]      req_tdata,   // sound_type, sound_priority, target_voice, pad
   input  logic             req_tuser,   // req_type
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [7:0]       rsp_tdata,   // voice_number, pad
   output logic [4:0]       rsp_tuser,   // granted, already_loaded, outcome
   input  logic             csr_wr_en,
   input  logic [CNT_W-1:0] csr_wr_data
);

   pva_cmd_type        cmd;
   pva_status_type     status;
   logic               rsp_granted;
   logic [VIDX_W-1:0]  rsp_voice_number;
   logic               rsp_already_loaded;
   logic [OUTC_W-1:0]  rsp_outcome;

   pva_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   pva_datapath u_dp (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .in_req_type        (req_tuser),
      .in_sound_type      (req_tdata[7:0]),
      .in_sound_priority  (req_tdata[12:8]),
      .in_target_voice    (req_tdata[17:13]),
      .cmd                (cmd),
      .status             (status),
      .rsp_granted        (rsp_granted),
      .rsp_voice_number   (rsp_voice_number),
      .rsp_already_loaded (rsp_already_loaded),
      .rsp_outcome        (rsp_outcome)
   );

   assign rsp_tdata = {3'b000, rsp_voice_number};
   assign rsp_tuser = {rsp_outcome, rsp_already_loaded, rsp_granted};

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stream-level test of the priority voice allocator core: directed corner
// cases, random allocate and stop traffic across several voice limits, and a
// long output hold-off, each result checked against a cycle-free model.
// ----------------------------------------------------------------------------
module tb;
   import pva_pkg::*;

   localparam int  CYCLE_LIMIT = 600000;
   localparam int  HOLD_CYCLES = 300;

   typedef struct packed {
      logic                 rtype;
      logic [SOUND_W-1:0]   sound;
      logic [PRIO_W-1:0]    prio;
      logic [VIDX_W-1:0]    target;
   } voice_req_type;

   typedef struct packed {
      logic                 granted;
      logic [VIDX_W-1:0]    voice;
      logic                 loaded;
      logic [OUTC_W-1:0]    outcome;
   } voice_rsp_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [23:0]      req_tdata = '0;   // sound_type, sound_priority, target_voice, pad
   logic             req_tuser = 1'b0; // req_type
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [7:0]       rsp_tdata;        // voice_number, pad
   logic [4:0]       rsp_tuser;        // granted, already_loaded, outcome
   logic             csr_wr_en = 1'b0;
   logic [CNT_W-1:0] csr_wr_data = '0;

   // allocator state as the block should hold it
   int               open_cnt;
   int               limit_now;
   logic [MAX_VOICES-1:0] playing;
   logic [SOUND_W-1:0]    sound_of [MAX_VOICES];
   logic [PRIO_W-1:0]     rank_of  [MAX_VOICES];

   voice_rsp_type    grants_due [$];
   int               fail_count = 0;
   int               cycle_count = 0;
   bit               src_gaps_on = 1'b1;
   bit               sink_gaps_on = 1'b1;
   int               hold_ticket = 0;
   int               hold_taken = 0;
   int               hold_left = 0;

   priority_voice_allocator_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words outstanding", cycle_count,
                  grants_due.size());
         $display("Verification failed");
         $finish;
      end
   end

   task automatic report_mismatch(string what, int want, int got);
      $display("%0t mismatch %s: expected %0d got %0d", $realtime, what, want, got);
      fail_count++;
   endtask

   // serve one request against the model state, return the result it causes
   function automatic voice_rsp_type grant_for(voice_req_type r);
      voice_rsp_type o;
      int            n;
      int            le;
      bit            le_found;
      o = '{granted: 1'b0, voice: '0, loaded: 1'b0, outcome: OUTC_REFUSED};
      n = (open_cnt > MAX_VOICES) ? MAX_VOICES : open_cnt;
      le = 0;
      le_found = 1'b0;
      if (r.rtype == REQ_STOP) begin
         if (int'(r.target) < n) begin
            playing[r.target] = 1'b0;
            o.granted = 1'b1;
            o.voice = r.target;
            o.outcome = OUTC_STOP_DONE;
         end
         return o;
      end
      for (int v = 0; v < n; v++) begin
         if (!playing[v] && sound_of[v] == r.sound) begin
            rank_of[v] = r.prio;
            playing[v] = 1'b1;
            o = '{granted: 1'b1, voice: VIDX_W'(v), loaded: 1'b1, outcome: OUTC_REUSED};
            return o;
         end
      end
      if (n < MAX_VOICES && (n == 0 || n < limit_now)) begin
         sound_of[n] = r.sound;
         rank_of[n] = r.prio;
         playing[n] = 1'b1;
         open_cnt = n + 1;
         o = '{granted: 1'b1, voice: VIDX_W'(n), loaded: 1'b0, outcome: OUTC_OPENED};
         return o;
      end
      for (int v = 0; v < n; v++) begin
         if (rank_of[v] < r.prio) begin
            sound_of[v] = r.sound;
            playing[v] = 1'b1;
            o = '{granted: 1'b1, voice: VIDX_W'(v), loaded: 1'b0, outcome: OUTC_STOLE_LT};
            return o;
         end
         if (rank_of[v] <= r.prio) begin
            le_found = 1'b1;
            le = v;
         end
      end
      if (le_found) begin
         sound_of[le] = r.sound;
         playing[le] = 1'b1;
         o = '{granted: 1'b1, voice: VIDX_W'(le), loaded: 1'b0, outcome: OUTC_STOLE_LE};
      end
      return o;
   endfunction

   // result side: check each accepted word, then drive ready
   always @(posedge clock) begin
      voice_rsp_type due;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (grants_due.size() == 0) begin
            report_mismatch("unexpected result word, voice", -1, int'(rsp_tdata[4:0]));
         end else begin
            due = grants_due.pop_front();
            if (rsp_tuser[0] !== due.granted)
               report_mismatch("granted", due.granted, rsp_tuser[0]);
            if (rsp_tdata[4:0] !== due.voice)
               report_mismatch("voice_number", due.voice, rsp_tdata[4:0]);
            if (rsp_tuser[1] !== due.loaded)
               report_mismatch("already_loaded", due.loaded, rsp_tuser[1]);
            if (rsp_tuser[4:2] !== due.outcome)
               report_mismatch("outcome", due.outcome, rsp_tuser[4:2]);
         end
      end
      if (hold_ticket != hold_taken) begin
         hold_taken <= hold_ticket;
         hold_left <= HOLD_CYCLES - 1;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !sink_gaps_on || ($urandom_range(99) >= 8);
      end
   end

   task automatic offer_word(voice_req_type w);
      int gap;
      gap = 0;
      if (src_gaps_on)
         while ($urandom_range(99) < 8) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {6'd0, w.target, w.prio, w.sound};
      req_tuser <= w.rtype;
      do @(posedge clock); while (!req_tready);
      grants_due.insert(grants_due.size(), grant_for(w));
   endtask

   task automatic alloc(int snd, int pri);
      offer_word('{rtype: REQ_ALLOC, sound: SOUND_W'(snd), prio: PRIO_W'(pri),
                   target: VIDX_W'($urandom_range(31))});
   endtask

   task automatic stop(int tgt);
      offer_word('{rtype: REQ_STOP, sound: SOUND_W'($urandom_range(255)),
                   prio: PRIO_W'($urandom_range(31)), target: VIDX_W'(tgt)});
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (grants_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_limit(int value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= CNT_W'(value);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      limit_now = value & 63;
   endtask

   // mostly well-formed traffic: stops of open voices and reloads of known sounds
   task automatic random_word();
      int pick;
      int n;
      pick = $urandom_range(9);
      n = (open_cnt > 0) ? open_cnt : 1;
      case (pick) inside
         [0:3]: alloc($urandom_range(15), $urandom_range(31));
         4:     alloc($urandom_range(255), $urandom_range(31));
         [5:6]: stop($urandom_range(n - 1));
         7:     stop($urandom_range(31));
         default: begin
            if (open_cnt > 0)
               alloc(sound_of[$urandom_range(open_cnt - 1)], $urandom_range(31));
            else
               alloc($urandom_range(255), $urandom_range(31));
         end
      endcase
   endtask

   task automatic test_directed_corners();
      write_limit(0);
      alloc(0, 31);        // empty pool opens even at limit zero
      stop(31);            // unopened voice
      stop(0);
      stop(0);             // already idle
      alloc(0, 0);         // reuse
      alloc(255, 0);       // steal lower-or-equal
      alloc(7, 31);        // steal lower
      wait_drained();
      write_limit(1);
      alloc(9, 0);
      wait_drained();
      write_limit(4);
      alloc(1, 10);
      alloc(2, 20);
      alloc(3, 20);
      alloc(4, 20);
      stop(0);
      alloc(4, 31);
      stop(1);
      alloc(1, 25);
      alloc(5, 20);        // last lower-or-equal voice
      alloc(6, 15);        // refused
      alloc(6, 0);
      alloc(255, 31);
      wait_drained();
   endtask

   task automatic test_random_limits();
      int limits [3] = '{6, 1, 17};
      foreach (limits[i]) begin
         write_limit(limits[i]);
         repeat (90) random_word();
         wait_drained();
      end
   endtask

   task automatic test_backpressure();
      src_gaps_on = 1'b0;
      hold_ticket <= hold_ticket + 1;
      repeat (30) random_word();
      wait_drained();
      src_gaps_on = 1'b1;
   endtask

   task automatic test_limit_saturate();
      write_limit(63);
      for (int i = 0; i < 40; i++) alloc(100 + i, $urandom_range(31));
      wait_drained();
      write_limit(32);
   endtask

   task automatic test_full_pool_random();
      src_gaps_on = 1'b0;
      sink_gaps_on <= 1'b0;
      repeat (150) random_word();
      src_gaps_on = 1'b1;
      sink_gaps_on <= 1'b1;
      repeat (350) random_word();
      wait_drained();
   endtask

   initial begin
      open_cnt = 0;
      limit_now = int'(LIMIT_RESET);
      playing = '0;
      foreach (sound_of[v]) begin
         sound_of[v] = '0;
         rank_of[v] = '0;
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_corners();
      test_random_limits();
      test_backpressure();
      test_limit_saturate();
      test_full_pool_random();
      repeat (20) @(posedge clock);
      if (fail_count == 0 && grants_due.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
